// ----- hw/rtl/stmin_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stmin_pkg
// Shared types and constants for the sparse-table range-minimum block.
// ----------------------------------------------------------------------------
package stmin_pkg;

    // fixed field widths of one beat
    localparam int DATA_W = 32;
    localparam int OP_W   = 2;
    localparam int IDX_W  = 10;
    // width of a query length, one more than an index
    localparam int LEN_W  = IDX_W + 1;
    // width of a bit position inside a query length
    localparam int KPOS_W = $clog2(LEN_W);

    // command codes
    typedef enum logic [OP_W-1:0] {
        OP_CLEAR  = 2'd0,
        OP_APPEND = 2'd1,
        OP_QUERY  = 2'd2
    } t_opcode;

    // result status codes
    typedef enum logic {
        STATUS_OK  = 1'b0,
        STATUS_BAD = 1'b1
    } t_status;

    // sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_APP,
        ST_QLEN,
        ST_QRD0,
        ST_QRD1,
        ST_QFIN
    } t_state;

endpackage

// ----- hw/rtl/stmin_mem.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stmin_mem
// Table memory: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module stmin_mem
    import stmin_pkg::*;
#(
    parameter int DEPTH = 11264,
    parameter int AW    = 14
) (
    input  logic              i_clk,
    input  logic              i_wr_en,
    input  logic [AW-1:0]     i_wr_addr,
    input  logic [DATA_W-1:0] i_wr_data,
    input  logic              i_rd_en,
    input  logic [AW-1:0]     i_rd_addr,
    output logic [DATA_W-1:0] o_rd_data
);

    logic [DATA_W-1:0] r_mem [DEPTH];
    logic [DATA_W-1:0] r_rd_data;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // read port, read data registered on a read enable
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ----- hw/rtl/stmin_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stmin_ctrl
// Command sequencer: level fill for appends, two-read lookup for queries.
// ----------------------------------------------------------------------------
module stmin_ctrl
    import stmin_pkg::*;
#(
    parameter int MAX_ELEMENTS = 1024,
    parameter int LEVELS       = 11,
    parameter int AW           = 14
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_start,
    output logic                     o_busy,
    input  logic [OP_W-1:0]          i_opcode,
    input  logic signed [DATA_W-1:0] i_value,
    input  logic [IDX_W-1:0]         i_range_start,
    input  logic [IDX_W-1:0]         i_range_end,
    output logic                     o_valid,
    output logic signed [DATA_W-1:0] o_minimum,
    output logic                     o_status,
    output logic                     o_wr_en,
    output logic [AW-1:0]            o_wr_addr,
    output logic [DATA_W-1:0]        o_wr_data,
    output logic                     o_rd_en,
    output logic [AW-1:0]            o_rd_addr,
    input  logic [DATA_W-1:0]        i_rd_data
);

    localparam int CW = $clog2(MAX_ELEMENTS + 1);
    localparam int IW = $clog2(MAX_ELEMENTS);
    localparam int LW = $clog2(LEVELS);
    localparam int RW = $clog2(LEVELS + 1);
    localparam int XW = (IW > LEN_W) ? IW : LEN_W;
    localparam int QW = (CW > LEN_W) ? CW : LEN_W;

    t_state                     r_state, n_state;
    logic [CW-1:0]              r_count;
    logic [IW-1:0]              r_pos;
    logic [RW-1:0]              r_rk;
    logic                       r_rdv;
    logic [LW-1:0]              r_wk;
    logic [IW-1:0]              r_first;
    logic signed [DATA_W-1:0]   r_acc;
    logic [IDX_W-1:0]           r_s;
    logic [IDX_W-1:0]           r_e;
    logic [LW-1:0]              r_k;
    logic                       r_valid;
    logic signed [DATA_W-1:0]   r_min;
    logic                       r_status;

    logic                       accept;
    logic                       bad_range;
    logic [CW-1:0]              pos_p1;
    logic                       issue;
    logic [IW-1:0]              rd_first;
    logic signed [DATA_W-1:0]   lower;
    logic [LEN_W-1:0]           q_len;
    logic [KPOS_W-1:0]          hb;
    logic [LEN_W-1:0]           q_end_first;

    // flat table address: level row times row length plus index
    function automatic logic [AW-1:0] f_addr(input logic [LW-1:0] lv,
                                             input logic [XW-1:0] idx);
        return AW'(AW'(lv) * AW'(MAX_ELEMENTS)) + AW'(idx);
    endfunction

    assign accept    = i_start && (r_state == ST_IDLE);
    assign o_busy    = (r_state != ST_IDLE);
    assign bad_range = (i_range_start > i_range_end)
                    || (QW'(i_range_end) >= QW'(r_count));

    // level fill bookkeeping: window of 2^rk ending at the new element
    assign pos_p1   = CW'(r_pos) + CW'(1);
    assign issue    = (32'(r_rk) < LEVELS) && ((pos_p1 >> r_rk) != '0);
    assign rd_first = IW'(pos_p1 - (CW'(1) << r_rk));

    // signed minimum of read word and running value
    assign lower = ($signed(i_rd_data) <= r_acc) ? $signed(i_rd_data) : r_acc;

    // query level: highest set bit of the length
    always_comb begin
        q_len = LEN_W'(r_e) - LEN_W'(r_s) + LEN_W'(1);
        hb    = '0;
        for (int i = 0; i < LEN_W; i++) begin
            if (q_len[i]) begin
                hb = KPOS_W'(i);
            end
        end
    end

    assign q_end_first = LEN_W'(r_e) + LEN_W'(1) - (LEN_W'(1) << r_k);

    // next state and memory port control
    always_comb begin
        n_state   = r_state;
        o_wr_en   = 1'b0;
        o_wr_addr = f_addr(r_wk, XW'(r_first));
        o_wr_data = lower;
        o_rd_en   = 1'b0;
        o_rd_addr = '0;
        case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    case (i_opcode)
                        OP_APPEND: begin
                            if (32'(r_count) < MAX_ELEMENTS) begin
                                o_wr_en   = 1'b1;
                                o_wr_addr = f_addr('0, XW'(r_count));
                                o_wr_data = i_value;
                                n_state   = ST_APP;
                            end
                        end
                        OP_QUERY: begin
                            if (!bad_range) begin
                                n_state = ST_QLEN;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_APP: begin
                if (issue) begin
                    o_rd_en   = 1'b1;
                    o_rd_addr = f_addr(LW'(r_rk - RW'(1)), XW'(rd_first));
                end
                if (r_rdv) begin
                    o_wr_en = 1'b1;
                end
                if (!issue && !r_rdv) begin
                    n_state = ST_IDLE;
                end
            end
            ST_QLEN: begin
                n_state = ST_QRD0;
            end
            ST_QRD0: begin
                o_rd_en   = 1'b1;
                o_rd_addr = f_addr(r_k, XW'(r_s));
                n_state   = ST_QRD1;
            end
            ST_QRD1: begin
                o_rd_en   = 1'b1;
                o_rd_addr = f_addr(r_k, XW'(q_end_first));
                n_state   = ST_QFIN;
            end
            ST_QFIN: begin
                n_state = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // element count, fill pipeline and result registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_rdv   <= 1'b0;
            r_valid <= 1'b0;
        end else begin
            r_valid <= 1'b0;
            r_rdv   <= (r_state == ST_APP) && issue;
            case (r_state)
                ST_IDLE: begin
                    if (accept) begin
                        case (i_opcode)
                            OP_CLEAR: begin
                                r_count <= '0;
                            end
                            OP_APPEND: begin
                                if (32'(r_count) < MAX_ELEMENTS) begin
                                    r_pos   <= IW'(r_count);
                                    r_count <= r_count + CW'(1);
                                    r_acc   <= i_value;
                                    r_rk    <= RW'(1);
                                end
                            end
                            OP_QUERY: begin
                                r_s <= i_range_start;
                                r_e <= i_range_end;
                                if (bad_range) begin
                                    r_valid  <= 1'b1;
                                    r_min    <= '0;
                                    r_status <= STATUS_BAD;
                                end
                            end
                            default: begin
                            end
                        endcase
                    end
                end
                ST_APP: begin
                    if (issue) begin
                        r_wk    <= LW'(r_rk);
                        r_first <= rd_first;
                        r_rk    <= r_rk + RW'(1);
                    end
                    // window just written feeds the next level directly
                    if (r_rdv) begin
                        r_acc <= lower;
                    end
                end
                ST_QLEN: begin
                    r_k <= (32'(hb) > LEVELS - 1) ? LW'(LEVELS - 1) : LW'(hb);
                end
                ST_QRD1: begin
                    r_acc <= $signed(i_rd_data);
                end
                ST_QFIN: begin
                    r_valid  <= 1'b1;
                    r_min    <= lower;
                    r_status <= STATUS_OK;
                end
                default: begin
                end
            endcase
        end
    end

    assign o_valid   = r_valid;
    assign o_minimum = r_min;
    assign o_status  = r_status;

endmodule

// ----- hw/rtl/sparse_table_range_min_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sparse_table_range_min_top
// Range-minimum queries over loaded signed elements via a sparse table.
// ----------------------------------------------------------------------------
// Query: busy through states QLEN, QRD0, QRD1 and QFIN, result strobe registered from QFIN.
// Bad range: result strobe in the cycle after start, busy stays low.
// Append: level 0 written on the start beat, then levels 1..K, K = min(LEVELS-1, floor(log2(
//   count after the append))); one table level per cycle on the read port.
// Clear: no result, busy stays low. Results cannot be stalled by the receiver.
// Reset clears the element count, state and result strobe; the table is not swept.
module sparse_table_range_min_top
    import stmin_pkg::*;
#(
    parameter int MAX_ELEMENTS = 1024,
    parameter int LEVELS       = 11
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     start,
    output logic                     busy,
    input  logic [OP_W-1:0]          i_opcode,
    input  logic signed [DATA_W-1:0] i_value,
    input  logic [IDX_W-1:0]         i_range_start,
    input  logic [IDX_W-1:0]         i_range_end,
    output logic                     o_valid,
    output logic signed [DATA_W-1:0] o_minimum,
    output logic                     o_status
);

    localparam int DEPTH = LEVELS * MAX_ELEMENTS;
    localparam int AW    = $clog2(DEPTH);

    logic              wr_en;
    logic [AW-1:0]     wr_addr;
    logic [DATA_W-1:0] wr_data;
    logic              rd_en;
    logic [AW-1:0]     rd_addr;
    logic [DATA_W-1:0] rd_data;

    // sequencer
    stmin_ctrl #(
        .MAX_ELEMENTS (MAX_ELEMENTS),
        .LEVELS       (LEVELS),
        .AW           (AW)
    ) u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_start       (start),
        .o_busy        (busy),
        .i_opcode      (i_opcode),
        .i_value       (i_value),
        .i_range_start (i_range_start),
        .i_range_end   (i_range_end),
        .o_valid       (o_valid),
        .o_minimum     (o_minimum),
        .o_status      (o_status),
        .o_wr_en       (wr_en),
        .o_wr_addr     (wr_addr),
        .o_wr_data     (wr_data),
        .o_rd_en       (rd_en),
        .o_rd_addr     (rd_addr),
        .i_rd_data     (rd_data)
    );

    // sparse table storage
    stmin_mem #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_mem (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

`ifndef ASSERT_OFF
    // a bad range always reports a zero minimum
    a_bad_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_status == STATUS_BAD)) |-> (o_minimum == '0))
        else $error("bad range beat with nonzero minimum");

    // a result beat follows a start beat or a busy cycle
    a_result_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> ($past(start) || $past(busy)))
        else $error("result beat without a command");

    // busy only rises after a start beat
    a_busy_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(busy) |-> $past(start))
        else $error("busy rose without a start beat");
`endif

endmodule

// ----- tb/tb_sparse_table_range_min_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_sparse_table_range_min_top
// Self-checking bench for the sparse-table range-minimum block. A queue of
// clear, append, query and unused-opcode beats is built up front: a short
// directed set, then random load/query rounds, then one long load of the
// array that reaches table level nine. A local predictor keeps its own
// element count and window-minimum table and checks every result strobe in order.
// ----------------------------------------------------------------------------
module tb_sparse_table_range_min_top;
    import stmin_pkg::*;

    localparam int MAX_ELEMENTS = 1024;
    localparam int LEVELS       = 11;
    localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
    localparam int MAX_REPORTS  = 10;
    localparam int DRAIN_CYCLES = 20;
    localparam int RAND_ITEMS   = 120;
    localparam int FILL_CNT     = 520;

    typedef struct {
        logic [OP_W-1:0]          op;
        logic signed [DATA_W-1:0] value;
        logic [IDX_W-1:0]         rs;
        logic [IDX_W-1:0]         re;
    } t_cmd;

    typedef struct {
        logic signed [DATA_W-1:0] minimum;
        t_status                  status;
    } t_answer;

    logic                     i_clk = 1'b0;
    logic                     i_rst_n = 1'b0;
    logic                     start = 1'b0;
    logic                     busy;
    logic [OP_W-1:0]          i_opcode = OP_CLEAR;
    logic signed [DATA_W-1:0] i_value = '0;
    logic [IDX_W-1:0]         i_range_start = '0;
    logic [IDX_W-1:0]         i_range_end = '0;
    logic                     o_valid;
    logic signed [DATA_W-1:0] o_minimum;
    logic                     o_status;

    // stimulus and prediction state
    t_cmd    cmd_q[$];
    t_answer answer_q[$];
    logic signed [DATA_W-1:0] win_min [LEVELS][MAX_ELEMENTS];
    int      loaded_cnt;
    int      err_count;
    bit      beat_taken;
    int      gap_left;
    int      gen_cnt;

    sparse_table_range_min_top #(
        .MAX_ELEMENTS (MAX_ELEMENTS),
        .LEVELS       (LEVELS)
    ) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .start         (start),
        .busy          (busy),
        .i_opcode      (i_opcode),
        .i_value       (i_value),
        .i_range_start (i_range_start),
        .i_range_end   (i_range_end),
        .o_valid       (o_valid),
        .o_minimum     (o_minimum),
        .o_status      (o_status)
    );

    // clock
    initial begin
        forever #10 i_clk = ~i_clk;
    end

    // signed minimum of two words
    function automatic logic signed [DATA_W-1:0] lower(
        logic signed [DATA_W-1:0] a, logic signed [DATA_W-1:0] b);
        return (a <= b) ? a : b;
    endfunction

    // update the local table for one accepted beat, queue any answer
    function automatic void predict_range_min(logic [OP_W-1:0] op,
        logic signed [DATA_W-1:0] val, logic [IDX_W-1:0] rs, logic [IDX_W-1:0] re);
        int      pos;
        int      span;
        int      first;
        int      len;
        int      lvl;
        t_answer ans;
        case (op)
            OP_CLEAR: loaded_cnt = 0;
            OP_APPEND: begin
                if (loaded_cnt < MAX_ELEMENTS) begin
                    pos = loaded_cnt;
                    win_min[0][pos] = val;
                    // refresh the one window per level that ends at the new element
                    for (int k = 1; k < LEVELS; k++) begin
                        span = 1 << k;
                        if (span > pos + 1) break;
                        first = pos + 1 - span;
                        win_min[k][first] = lower(win_min[k-1][first],
                                                  win_min[k-1][first + span/2]);
                    end
                    loaded_cnt++;
                end
            end
            OP_QUERY: begin
                if (rs > re || int'(re) >= loaded_cnt) begin
                    ans.minimum = '0;
                    ans.status  = STATUS_BAD;
                end else begin
                    len = int'(re) - int'(rs) + 1;
                    lvl = 0;
                    while (lvl + 1 < LEVELS && (len >> (lvl + 1)) != 0) lvl++;
                    ans.minimum = lower(win_min[lvl][rs],
                                        win_min[lvl][int'(re) + 1 - (1 << lvl)]);
                    ans.status  = STATUS_OK;
                end
                answer_q.insert(answer_q.size(), ans);
            end
            default: ;
        endcase
    endfunction

    // element values biased toward the signed extremes
    function automatic logic signed [DATA_W-1:0] pick_value();
        case ($urandom_range(0, 9))
            0: return 32'sh8000_0000;
            1: return 32'sh7fff_ffff;
            2: return '0;
            3: return -32'sd1;
            4: return $signed($urandom_range(0, 20)) - 32'sd10;
            default: return $signed($urandom);
        endcase
    endfunction

    function automatic void add_cmd(logic [OP_W-1:0] op, logic signed [DATA_W-1:0] val,
        int rs, int re);
        t_cmd c;
        c.op    = op;
        c.value = val;
        c.rs    = rs[IDX_W-1:0];
        c.re    = re[IDX_W-1:0];
        cmd_q.insert(cmd_q.size(), c);
        if (op == OP_CLEAR) gen_cnt = 0;
        if (op == OP_APPEND && gen_cnt < MAX_ELEMENTS) gen_cnt++;
    endfunction

    // query over the currently loaded span, short ranges favored
    function automatic void add_good_query();
        int s;
        int e;
        int d;
        s = $urandom_range(0, gen_cnt - 1);
        d = $urandom_range(0, 7);
        case ($urandom_range(0, 3))
            0: e = s;
            1: e = (s + d < gen_cnt) ? s + d : gen_cnt - 1;
            default: e = $urandom_range(s, gen_cnt - 1);
        endcase
        add_cmd(OP_QUERY, $signed($urandom), s, e);
    endfunction

    // garbage query fields, mostly out of range
    function automatic void add_bad_query();
        int s;
        int e;
        if ($urandom_range(0, 1) == 0) begin
            e = $urandom_range(0, 1022);
            s = $urandom_range(e + 1, 1023);
        end else begin
            s = $urandom_range(0, 1023);
            e = $urandom_range(0, 1023);
        end
        add_cmd(OP_QUERY, $signed($urandom), s, e);
    endfunction

    // beat driver, inputs change on the falling edge
    always @(negedge i_clk) begin
        t_cmd c;
        if (i_rst_n && (!start || beat_taken)) begin
            if (gap_left > 0) begin
                gap_left--;
                start <= 1'b0;
            end else if (cmd_q.size() > 0 && cmd_q.size() > 150 && $urandom_range(0, 5) == 0) begin
                gap_left = $urandom_range(1, 6) - 1;
                start <= 1'b0;
            end else if (cmd_q.size() > 0) begin
                c = cmd_q.pop_front();
                i_opcode      <= c.op;
                i_value       <= c.value;
                i_range_start <= c.rs;
                i_range_end   <= c.re;
                start         <= 1'b1;
            end else begin
                start <= 1'b0;
            end
        end
    end

    // result monitor and predictor update
    always @(posedge i_clk) begin
        t_answer exp_ans;
        beat_taken = 1'b0;
        if (i_rst_n) begin
            // check a strobe against the oldest pending answer
            if (o_valid) begin
                if (answer_q.size() == 0) begin
                    err_count++;
                    if (err_count <= MAX_REPORTS)
                        $display("unexpected result: minimum=%0d status=%0d",
                                 o_minimum, o_status);
                end else begin
                    exp_ans = answer_q.pop_front();
                    if (o_minimum !== exp_ans.minimum || o_status !== exp_ans.status) begin
                        err_count++;
                        if (err_count <= MAX_REPORTS)
                            $display({"mismatch: expected minimum=%0d status=%0d,",
                                      " got minimum=%0d status=%0d"},
                                     exp_ans.minimum, exp_ans.status, o_minimum, o_status);
                    end
                end
            end
            // command accepted on this edge
            if (start && !busy) begin
                beat_taken = 1'b1;
                predict_range_min(i_opcode, i_value, i_range_start, i_range_end);
            end
        end
    end

    // stimulus build, reset and end of run
    initial begin
        int n_items;
        int target;
        int n_q;
        loaded_cnt = 0;
        err_count  = 0;
        gap_left   = 0;
        gen_cnt    = 0;

        // directed: extremes, length one, overlap, bad ranges, unused opcode
        add_cmd(OP_QUERY, 0, 0, 0);
        add_cmd(OP_APPEND, 32'sh8000_0000, 0, 0);
        add_cmd(OP_APPEND, 32'sh7fff_ffff, 0, 0);
        add_cmd(OP_APPEND, 0, 0, 0);
        add_cmd(OP_APPEND, -32'sd1, 0, 0);
        add_cmd(OP_QUERY, 0, 0, 0);
        add_cmd(OP_QUERY, 0, 1, 1);
        add_cmd(OP_QUERY, 0, 1, 3);
        add_cmd(OP_QUERY, 0, 0, 3);
        add_cmd(OP_QUERY, 0, 1, 2);
        add_cmd(OP_QUERY, 0, 3, 1);
        add_cmd(OP_QUERY, 0, 0, 4);
        add_cmd(OP_QUERY, 32'sh7fff_ffff, 1023, 1023);
        add_cmd(OP_UNUSED, 32'sh8000_0000, 1023, 1023);
        add_cmd(OP_APPEND, 5, 0, 0);
        add_cmd(OP_QUERY, 0, 2, 4);
        add_cmd(OP_CLEAR, 0, 0, 0);
        add_cmd(OP_QUERY, 0, 0, 0);
        add_cmd(OP_APPEND, 32'sd100, 0, 0);
        add_cmd(OP_APPEND, 32'sd7, 0, 0);
        add_cmd(OP_QUERY, 0, 0, 1);
        add_cmd(OP_QUERY, 0, 0, 2);

        // random rounds: clear, load a short array, query it
        n_items = 0;
        while (n_items < RAND_ITEMS) begin
            add_cmd(OP_CLEAR, $signed($urandom), $urandom_range(0, 1023),
                    $urandom_range(0, 1023));
            n_items++;
            case ($urandom_range(0, 19))
                0:       target = $urandom_range(41, 200);
                1, 2, 3: target = $urandom_range(17, 40);
                default: target = $urandom_range(1, 16);
            endcase
            for (int i = 0; i < target; i++) begin
                add_cmd(OP_APPEND, pick_value(), $urandom_range(0, 1023),
                        $urandom_range(0, 1023));
                n_items++;
                if ($urandom_range(0, 5) == 0) begin
                    add_good_query();
                    n_items++;
                end
            end
            n_q = $urandom_range(3, 20);
            for (int i = 0; i < n_q; i++) begin
                case ($urandom_range(0, 19))
                    0, 1: add_bad_query();
                    2:    add_cmd(OP_UNUSED, $signed($urandom), $urandom_range(0, 1023),
                                  $urandom_range(0, 1023));
                    default: add_good_query();
                endcase
                n_items++;
            end
        end

        // long load up to level nine, then query wide and edge spans
        add_cmd(OP_CLEAR, 0, 0, 0);
        for (int i = 0; i < FILL_CNT; i++)
            add_cmd(OP_APPEND, pick_value(), $urandom_range(0, 1023),
                    $urandom_range(0, 1023));
        add_cmd(OP_QUERY, 0, 0, FILL_CNT - 1);
        add_cmd(OP_QUERY, 0, FILL_CNT - 1, FILL_CNT - 1);
        add_cmd(OP_QUERY, 0, 1, FILL_CNT - 1);
        add_cmd(OP_QUERY, 0, 8, FILL_CNT - 1);
        add_cmd(OP_QUERY, 0, 0, 511);
        add_cmd(OP_QUERY, 0, FILL_CNT - 1, 0);
        add_cmd(OP_QUERY, 0, 0, FILL_CNT);
        for (int i = 0; i < 30; i++) add_good_query();

        // reset
        repeat (9) @(posedge i_clk);
        @(negedge i_clk) i_rst_n <= 1'b1;

        // drain stimulus, pending answers, then trailing cycles
        while (cmd_q.size() != 0 || start) @(posedge i_clk);
        while (answer_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (err_count == 0)
            $display("tb_sparse_table_range_min_top: clean");
        else
            $display("tb_sparse_table_range_min_top: errors");
        $finish;
    end

    // watchdog
    initial begin
        #5_000_000;
        $display("tb_sparse_table_range_min_top: errors");
        $finish;
    end

endmodule
